>>> design/adc_running_mean_to_millivolts_top_defines.svh
// Assertion macros for the checker file of the running-mean block.
`ifndef ADC_RUNNING_MEAN_TO_MILLIVOLTS_TOP_DEFINES_SVH
`define ADC_RUNNING_MEAN_TO_MILLIVOLTS_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ARM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arm assertion failed");

// next-cycle implication, disabled in reset
`define ARM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arm assertion failed");

`endif

>>> design/arm_pkg.sv
// Shared types and constants of the running-mean millivolt block.
package arm_pkg;

    localparam int CNT_W       = 16;
    localparam int MV_W        = 13;
    localparam int SUPPLY_W    = 13;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CNT_W-1:0]    WINDOW_RESET = 16'd10000;
    localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 13'd3300;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_SUPPLY = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic update;
        logic push;
    } arm_cmd_t;

    typedef struct packed {
        logic emit;
    } arm_status_t;

endpackage

>>> design/arm_ctrl.sv
// Sequencer: accept, serial divide, mean update, result push.
module arm_ctrl #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  arm_pkg::arm_status_t status,
    output arm_pkg::arm_cmd_t    cmd
);
    import arm_pkg::*;

    localparam int STEP_W = $clog2(SAMPLE_BITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLE_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_PUSH
    } state_t;

    state_t             state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               m_tvalid_reg;
    logic               can_push;

    assign can_push = !m_tvalid_reg || m_tready;

    always_comb
    begin
        cmd.load     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.update   = (state_reg == ST_UPD);
        cmd.push     = (state_reg == ST_PUSH) && can_push;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (s_tvalid)
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                        state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    state_reg <= status.emit ? ST_PUSH : ST_IDLE;
                end
                ST_PUSH:
                begin
                    if (can_push)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/arm_dpath.sv
// Datapath: config registers, mean and count, restoring divider, scaler.
module arm_dpath #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_sel,
    input  logic [arm_pkg::APB_DATA_W-1:0]     cfg_wdata,
    output logic [arm_pkg::APB_DATA_W-1:0]     cfg_rdata,
    input  logic [SAMPLE_BITS-1:0]             sample,
    input  arm_pkg::arm_cmd_t                  cmd,
    output arm_pkg::arm_status_t               status,
    output logic [arm_pkg::MV_W-1:0]           millivolts
);
    import arm_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic [CNT_W-1:0]    window_reg;
    logic [SUPPLY_W-1:0] supply_reg;
    logic [SB-1:0]       mean_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SB-1:0]       qd_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic                neg_reg;
    logic [SB+SUPPLY_W-1:0] prod_reg;
    logic [MV_W-1:0]     mv_reg;

    logic [CNT_W-1:0]    count_inc;
    logic [CNT_W-1:0]    count_next;
    logic [SB:0]         diff;
    logic [SB:0]         diff_mag;
    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      rem_sub;
    logic                q_bit;
    logic [SB:0]         step;
    logic [SB:0]         mean_sum;
    logic [SB-1:0]       mean_next;
    logic [CNT_W-1:0]    win_eff;

    always_comb
    begin
        count_inc  = count_reg + 1'b1;
        count_next = (count_inc == '0) ? CNT_W'(1) : count_inc;
        diff       = {1'b0, sample} - {1'b0, mean_reg};
        diff_mag   = diff[SB] ? (~diff + 1'b1) : diff;

        rem_sh  = {rem_reg, qd_reg[SB-1]};
        rem_sub = rem_sh - {1'b0, count_reg};
        q_bit   = (rem_sh >= {1'b0, count_reg});

        // the step never overshoots the sample, so the sum stays in range
        step      = neg_reg ? (~{1'b0, qd_reg} + 1'b1) : {1'b0, qd_reg};
        mean_sum  = {1'b0, mean_reg} + step;
        mean_next = mean_sum[SB-1:0];

        win_eff     = (window_reg == '0) ? CNT_W'(1) : window_reg;
        status.emit = (count_reg >= win_eff);
    end

    always_comb
    begin
        case (cfg_sel)
            REG_WINDOW: cfg_rdata = APB_DATA_W'(window_reg);
            REG_SUPPLY: cfg_rdata = APB_DATA_W'(supply_reg);
            default:    cfg_rdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            supply_reg <= SUPPLY_RESET;
            mean_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we && cfg_sel == REG_WINDOW)
                window_reg <= cfg_wdata[CNT_W-1:0];
            if (cfg_we && cfg_sel == REG_SUPPLY)
                supply_reg <= cfg_wdata[SUPPLY_W-1:0];

            if (cmd.load)
                count_reg <= count_next;

            if (cmd.update)
            begin
                if (status.emit)
                begin
                    mean_reg  <= '0;
                    count_reg <= '0;
                end
                else
                    mean_reg <= mean_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qd_reg  <= diff_mag[SB-1:0];
            rem_reg <= '0;
            neg_reg <= diff[SB];
        end
        else if (cmd.div_step)
        begin
            qd_reg  <= {qd_reg[SB-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end

        if (cmd.update)
            prod_reg <= mean_next * supply_reg;

        if (cmd.push)
            mv_reg <= prod_reg[SB +: MV_W];
    end

    assign millivolts = mv_reg;

endmodule

>>> design/adc_running_mean_to_millivolts_top.sv
// Each sample is accepted, divided by the one-bit-per-cycle divider, then folded into
// the mean; a new sample is taken only after the mean update of the last one. When the
// window count is reached, a result is pushed, waiting while an earlier one is held.
// A waiting result sits in the output register while the next sample is taken.
// Reset (rst_n low, async): mean and count clear, window 10000, supply 3300 mV.
module adc_running_mean_to_millivolts_top #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]   s_tdata,  // sample
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [arm_pkg::OUT_TDATA_W-1:0]            m_tdata,  // millivolts
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [arm_pkg::APB_ADDR_W-1:0]             paddr,
    input  logic [arm_pkg::APB_DATA_W-1:0]             pwdata,
    output logic [arm_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                       pready
);
    import arm_pkg::*;

    arm_cmd_t        cmd;
    arm_status_t     status;
    logic [MV_W-1:0] millivolts;
    logic            cfg_we;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign m_tdata = OUT_TDATA_W'(millivolts);

    arm_ctrl #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status  (status),
        .cmd     (cmd)
    );

    arm_dpath #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_sel   (paddr[2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .cmd       (cmd),
        .status    (status),
        .millivolts(millivolts)
    );

endmodule

>>> design/arm_checker.sv
// Port-level checks of the running-mean block, bound to the top level.
`include "adc_running_mean_to_millivolts_top_defines.svh"

module arm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [arm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import arm_pkg::*;

    `ARM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ARM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `ARM_ASSERT_NOW(a_result_from_busy, clk, rst_n, $rose(m_tvalid), $past(!s_tready))
    `ARM_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[OUT_TDATA_W-1:MV_W] == '0)

endmodule

bind adc_running_mean_to_millivolts_top arm_checker u_arm_checker (.*);
